@@ hdl/msa_pkg.sv @@
package msa_pkg;

  // Result status codes.
  localparam logic [1:0] STATUS_OK    = 2'd0;
  localparam logic [1:0] STATUS_OVER  = 2'd1;
  localparam logic [1:0] STATUS_UNDER = 2'd2;
  localparam logic [1:0] STATUS_BAD   = 2'd3;

  // Operation codes.
  localparam logic OP_PUSH = 1'b0;
  localparam logic OP_POP  = 1'b1;

  // Word returned by a pop from an empty stack.
  localparam logic signed [31:0] UNDERFLOW_WORD = -32'sd999999;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;    // capture the incoming word
    logic lookup;  // segment base and fill level
    logic exec;    // memory access and fill update
  } msa_cmd_t;

endpackage

@@ hdl/multi_stack_shared_array.sv @@
// A word taken at a clock edge passes through the lookup, memory access and response
// steps of the sequencer and gives its result, with done_o high, in the response step;
// busy_o holds off a new word during the lookup and memory access steps.
// A new word may be started in the response cycle; the receiver cannot stall.
// Reset (asynchronous, active low) empties all stacks and selects one stack.
module multi_stack_shared_array #(
  parameter int DEPTH      = 32,
  parameter int MAX_STACKS = 8
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  output logic               busy_o,
  output logic               done_o,
  input  logic               cfg_we_i,
  input  logic [3:0]         cfg_data_i,
  input  logic               opcode_i,
  input  logic [2:0]         stack_index_i,
  input  logic signed [31:0] push_value_i,
  output logic signed [31:0] pop_value_o,
  output logic [1:0]         status_o
);
  import msa_pkg::*;

  msa_cmd_t cmd;

  msa_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start_i),
    .busy_o  (busy_o),
    .done_o  (done_o),
    .cmd_o   (cmd)
  );

  msa_datapath #(
    .DEPTH      (DEPTH),
    .MAX_STACKS (MAX_STACKS)
  ) u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .cfg_we_i      (cfg_we_i),
    .cfg_data_i    (cfg_data_i),
    .opcode_i      (opcode_i),
    .stack_index_i (stack_index_i),
    .push_value_i  (push_value_i),
    .pop_value_o   (pop_value_o),
    .status_o      (status_o)
  );

endmodule

@@ hdl/msa_ctrl.sv @@
module msa_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  output logic              busy_o,
  output logic              done_o,
  output msa_pkg::msa_cmd_t cmd_o
);
  import msa_pkg::*;

  localparam logic [1:0] S_IDLE   = 2'd0;
  localparam logic [1:0] S_LOOKUP = 2'd1;
  localparam logic [1:0] S_EXEC   = 2'd2;
  localparam logic [1:0] S_RESP   = 2'd3;

  logic [1:0] state_q, state_d;
  logic       accept;

  // The response cycle does not block a new word.
  assign busy_o = (state_q == S_LOOKUP) || (state_q == S_EXEC);
  assign accept = start_i && !busy_o;
  assign done_o = (state_q == S_RESP);

  always_comb begin
    cmd_o.load   = accept;
    cmd_o.lookup = (state_q == S_LOOKUP);
    cmd_o.exec   = (state_q == S_EXEC);
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE:   if (accept) state_d = S_LOOKUP;
      S_LOOKUP: state_d = S_EXEC;
      S_EXEC:   state_d = S_RESP;
      S_RESP:   state_d = accept ? S_LOOKUP : S_IDLE;
      default:  state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  a_exec_then_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.exec |=> done_o)
    else $error("execute cycle not followed by a response");

  a_accept_goes_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> (busy_o && !done_o))
    else $error("accepted word did not occupy the block");

  a_done_one_cycle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o)
    else $error("response held for more than one cycle");

endmodule

@@ hdl/msa_datapath.sv @@
module msa_datapath #(
  parameter int DEPTH      = 32,
  parameter int MAX_STACKS = 8
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  msa_pkg::msa_cmd_t   cmd_i,
  input  logic                cfg_we_i,
  input  logic [3:0]          cfg_data_i,
  input  logic                opcode_i,
  input  logic [2:0]          stack_index_i,
  input  logic signed [31:0]  push_value_i,
  output logic signed [31:0]  pop_value_o,
  output logic [1:0]          status_o
);
  import msa_pkg::*;

  // Only eight stacks can be addressed by the index field.
  localparam int NSLOT = (MAX_STACKS < 8) ? MAX_STACKS : 8;
  localparam int SW    = (NSLOT > 1) ? $clog2(NSLOT) : 1;
  localparam int AW    = $clog2(DEPTH + 1);
  localparam int IW    = $clog2(DEPTH);

  logic [AW-1:0] seg_tab [16];

  for (genvar K = 0; K < 16; K++) begin : g_seg
    if (K == 0) begin : g_zero
      assign seg_tab[K] = '0;
    end else begin : g_div
      assign seg_tab[K] = AW'(DEPTH / K);
    end
  end

  logic [3:0]           num_q;
  logic [AW-1:0]        seg_q;
  logic [AW-1:0]        fill_q [NSLOT];
  logic [31:0]          mem [DEPTH];

  logic                 op_q;
  logic [2:0]           idx_q;
  logic signed [31:0]   val_q;
  logic [AW-1:0]        base_q;
  logic [AW-1:0]        cur_q;
  logic                 bad_q;
  logic                 last_q;
  logic [1:0]           status_q;
  logic                 pop_ok_q;
  logic [31:0]          rd_q;

  logic [3:0]           cfg_v;
  logic [SW-1:0]        slot;
  logic [AW+2:0]        prod;
  logic [AW-1:0]        cap;
  logic [AW-1:0]        addr_full;
  logic [IW-1:0]        addr;
  logic                 do_push;
  logic                 do_pop;
  logic [1:0]           status_d;

  // Zero is taken as one stack; larger values saturate.
  always_comb begin
    cfg_v = cfg_data_i;
    if (cfg_v == 4'd0) begin
      cfg_v = 4'd1;
    end
    if ({3'd0, cfg_v} > 7'(MAX_STACKS)) begin
      cfg_v = 4'(MAX_STACKS);
    end
  end

  // An index beyond the slots is rejected anyway; steer it to a legal slot.
  assign slot = ({4'd0, idx_q} < 7'(NSLOT)) ? SW'(idx_q) : '0;
  assign prod = (AW + 3)'(idx_q) * (AW + 3)'(seg_q);
  assign cap  = last_q ? AW'(DEPTH[AW-1:0] - base_q) : seg_q;

  always_comb begin
    do_push  = 1'b0;
    do_pop   = 1'b0;
    status_d = STATUS_OK;
    if (bad_q) begin
      status_d = STATUS_BAD;
    end else if (op_q == OP_PUSH) begin
      if (cur_q >= cap) begin
        status_d = STATUS_OVER;
      end else begin
        do_push = 1'b1;
      end
    end else begin
      if (cur_q == '0) begin
        status_d = STATUS_UNDER;
      end else begin
        do_pop = 1'b1;
      end
    end
  end

  assign addr_full = do_pop ? AW'(base_q + cur_q - AW'(1)) : AW'(base_q + cur_q);
  assign addr      = addr_full[IW-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      num_q <= 4'd1;
      seg_q <= AW'(DEPTH);
      for (int i = 0; i < NSLOT; i++) begin
        fill_q[i] <= '0;
      end
    end else if (cfg_we_i) begin
      num_q <= cfg_v;
      seg_q <= seg_tab[cfg_v];
      for (int i = 0; i < NSLOT; i++) begin
        fill_q[i] <= '0;
      end
    end else if (cmd_i.exec) begin
      if (do_push) begin
        fill_q[slot] <= cur_q + AW'(1);
      end else if (do_pop) begin
        fill_q[slot] <= cur_q - AW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      op_q  <= opcode_i;
      idx_q <= stack_index_i;
      val_q <= push_value_i;
    end
    if (cmd_i.lookup) begin
      base_q <= prod[AW-1:0];
      cur_q  <= fill_q[slot];
      bad_q  <= ({1'b0, idx_q} >= num_q);
      last_q <= ({1'b0, idx_q} + 4'd1 == num_q);
    end
    if (cmd_i.exec) begin
      status_q <= status_d;
      pop_ok_q <= do_pop;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.exec && do_push) begin
      mem[addr] <= val_q;
    end
    if (cmd_i.exec && do_pop) begin
      rd_q <= mem[addr];
    end
  end

  assign status_o = status_q;

  always_comb begin
    if (pop_ok_q) begin
      pop_value_o = rd_q;
    end else if (status_q == STATUS_UNDER) begin
      pop_value_o = UNDERFLOW_WORD;
    end else begin
      pop_value_o = '0;
    end
  end

endmodule

@@ sim/tb_top.sv @@
`timescale 1ns / 1ps

module tb_top;
  import msa_pkg::*;

  localparam int DEPTH      = 32;
  localparam int MAX_STACKS = 8;
  localparam int RAND_ITEMS = 52;

  typedef struct packed {
    logic               op;
    logic [2:0]         idx;
    logic signed [31:0] value;
  } stack_op_t;

  typedef struct packed {
    logic signed [31:0] value;
    logic [1:0]         status;
  } stack_reply_t;

  logic               clk_i         = 1'b0;
  logic               rst_ni        = 1'b0;
  logic               start_i       = 1'b0;
  logic               cfg_we_i      = 1'b0;
  logic [3:0]         cfg_data_i    = 4'd0;
  logic               opcode_i      = OP_PUSH;
  logic [2:0]         stack_index_i = 3'd0;
  logic signed [31:0] push_value_i  = 32'sd0;
  logic               busy_o;
  logic               done_o;
  logic signed [31:0] pop_value_o;
  logic [1:0]         status_o;

  multi_stack_shared_array #(
    .DEPTH(DEPTH),
    .MAX_STACKS(MAX_STACKS)
  ) uut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start_i      (start_i),
    .busy_o       (busy_o),
    .done_o       (done_o),
    .cfg_we_i     (cfg_we_i),
    .cfg_data_i   (cfg_data_i),
    .opcode_i     (opcode_i),
    .stack_index_i(stack_index_i),
    .push_value_i (push_value_i),
    .pop_value_o  (pop_value_o),
    .status_o     (status_o)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // Shadow copy of the stacks, updated as each word is accepted.
  logic signed [31:0] shadow_mem [DEPTH];
  int unsigned        shadow_fill [MAX_STACKS];
  int unsigned        shadow_seg  = DEPTH;
  int unsigned        shadow_cnt  = 1;

  stack_op_t    stack_op_q[$];
  stack_reply_t due_reply_q[$];
  int unsigned  mismatches = 0;
  bit           no_gaps    = 1'b0;

  function automatic int unsigned stack_capacity(int unsigned s);
    if (s + 1 == shadow_cnt) begin
      return DEPTH - s * shadow_seg;
    end
    return shadow_seg;
  endfunction

  function automatic stack_reply_t apply_stack_op(stack_op_t w);
    stack_reply_t r;
    int unsigned  s;
    int unsigned  fill;
    int unsigned  addr;
    r.value  = 32'sd0;
    r.status = STATUS_OK;
    s        = w.idx;
    fill     = shadow_fill[s % MAX_STACKS];
    if (s >= shadow_cnt) begin
      r.status = STATUS_BAD;
    end else if (w.op == OP_PUSH) begin
      if (fill >= stack_capacity(s)) begin
        r.status = STATUS_OVER;
      end else begin
        addr = s * shadow_seg + fill;
        if (addr < DEPTH) shadow_mem[addr] = w.value;
        shadow_fill[s] = fill + 1;
      end
    end else begin
      if (fill == 0) begin
        r.status = STATUS_UNDER;
        r.value  = UNDERFLOW_WORD;
      end else begin
        addr = s * shadow_seg + fill - 1;
        if (addr < DEPTH) r.value = shadow_mem[addr];
        shadow_fill[s] = fill - 1;
      end
    end
    return r;
  endfunction

  // Driver: a word is taken when start is high and busy is low at the edge.
  always @(posedge clk_i) begin
    stack_op_t w;
    if (rst_ni) begin
      if (start_i && !busy_o) begin
        w.op    = opcode_i;
        w.idx   = stack_index_i;
        w.value = push_value_i;
        due_reply_q.push_back(apply_stack_op(w));
      end
      if (!start_i || !busy_o) begin
        if (stack_op_q.size() > 0 && (no_gaps || $urandom_range(99) >= 31)) begin
          w = stack_op_q.pop_front();
          opcode_i      <= w.op;
          stack_index_i <= w.idx;
          push_value_i  <= w.value;
          start_i       <= 1'b1;
        end else begin
          start_i <= 1'b0;
        end
      end
    end
  end

  // Monitor: results cannot be held off, so every strobe is checked.
  always @(posedge clk_i) begin
    stack_reply_t exp_r;
    if (rst_ni && done_o) begin
      if (due_reply_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("Unexpected result word: pop_value %0d status %0d", pop_value_o, status_o);
        end
      end else begin
        exp_r = due_reply_q.pop_front();
        if (pop_value_o !== exp_r.value || status_o !== exp_r.status) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("Mismatch: pop_value exp %0d got %0d, status exp %0d got %0d",
                     exp_r.value, pop_value_o, exp_r.status, status_o);
          end
        end
      end
    end
  end

  task automatic add_op(logic op, logic [2:0] idx, logic signed [31:0] value);
    stack_op_t w;
    w.op    = op;
    w.idx   = idx;
    w.value = value;
    stack_op_q.push_back(w);
  endtask

  // Checked on the falling edge, once every update of the rising edge has settled.
  task automatic drain;
    while (stack_op_q.size() > 0 || start_i || due_reply_q.size() > 0) begin
      @(negedge clk_i);
    end
  endtask

  // Drains the block before the write, so the shadow state can change at once.
  task automatic set_stack_count(logic [3:0] v);
    int unsigned n;
    drain();
    @(posedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_data_i <= v;
    n = (v == 0) ? 1 : ((v > MAX_STACKS) ? MAX_STACKS : v);
    shadow_cnt = n;
    shadow_seg = DEPTH / n;
    foreach (shadow_fill[i]) shadow_fill[i] = 0;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic add_random_ops(int count, int push_pct);
    logic signed [31:0] v;
    logic [2:0]         idx;
    for (int i = 0; i < count; i++) begin
      case ($urandom_range(7))
        0:       v = 32'sh8000_0000;
        1:       v = 32'sh7fff_ffff;
        default: v = $urandom;
      endcase
      if ($urandom_range(99) < 85) idx = 3'($urandom_range(shadow_cnt - 1));
      else idx = 3'($urandom_range(7));
      add_op(($urandom_range(99) < push_pct) ? OP_PUSH : OP_POP, idx, v);
    end
  endtask

  initial begin
    logic [3:0] cfg_seq [11] = '{4'd0, 4'd15, 4'd3, 4'd8, 4'd5, 4'd2, 4'd7, 4'd1, 4'd9,
                                 4'd4, 4'd6};
    foreach (shadow_fill[i]) shadow_fill[i] = 0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;

    // One stack out of reset: underflow, extreme values and rejected indexes.
    add_op(OP_POP,  3'd0, 32'sd0);
    add_op(OP_PUSH, 3'd0, 32'sh8000_0000);
    add_op(OP_PUSH, 3'd0, 32'sh7fff_ffff);
    add_op(OP_PUSH, 3'd0, -32'sd1);
    add_op(OP_POP,  3'd0, 32'sd0);
    add_op(OP_POP,  3'd0, 32'sd0);
    add_op(OP_POP,  3'd0, 32'sd0);
    add_op(OP_POP,  3'd0, 32'sd0);
    add_op(OP_PUSH, 3'd7, 32'sd5);
    add_op(OP_POP,  3'd1, 32'sd0);

    // Eight stacks: fill the first and the last to overflow.
    set_stack_count(4'd8);
    for (int i = 0; i < 5; i++) add_op(OP_PUSH, 3'd0, 32'sd100 + i);
    for (int i = 0; i < 5; i++) add_op(OP_PUSH, 3'd7, -32'sd200 - i);
    add_op(OP_POP, 3'd7, 32'sd0);
    add_op(OP_POP, 3'd3, 32'sd0);

    foreach (cfg_seq[p]) begin
      set_stack_count(cfg_seq[p]);
      no_gaps = (p == 4);
      add_random_ops(RAND_ITEMS / 2, 80);
      // Hold the sender back until every outstanding result has been seen.
      drain();
      add_random_ops(RAND_ITEMS - RAND_ITEMS / 2, 25);
    end

    drain();
    repeat (10) @(posedge clk_i);
    if (mismatches == 0 && due_reply_q.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("Simulation FAILED");
    $finish;
  end

endmodule

@@ files.f @@
hdl/msa_pkg.sv
hdl/msa_ctrl.sv
hdl/msa_datapath.sv
hdl/multi_stack_shared_array.sv
sim/tb_top.sv
